// File: hdl/cqm_pkg.sv
// Shared types and constants for the completion queue manager.
`timescale 1ns / 1ps
`default_nettype none
package cqm_pkg;

  localparam int unsigned IDX_W    = 16;
  localparam int unsigned STATUS_W = 15;
  localparam int unsigned DW_W     = 32;
  localparam int unsigned UPPER_W  = 64;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Bit positions inside the upper quadword of an entry.
  localparam int unsigned SQID_LSB  = 16;
  localparam int unsigned CMDID_LSB = 32;
  localparam int unsigned PHASE_POS = 48;
  localparam int unsigned STATUS_LSB = 49;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_SIZE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLED = 8'd1;

  localparam logic [IDX_W-1:0] QSIZE_RESET = 16'd2;

  typedef enum logic [2:0] {
    CMD_RESERVE  = 3'd0,
    CMD_WRITE_IO = 3'd1,
    CMD_WRITE_ADMIN = 3'd2,
    CMD_DOORBELL = 3'd3,
    CMD_FLUSH    = 3'd4
  } cmd_e_t;

  typedef enum logic [2:0] {
    IRQ_NONE       = 3'd0,
    IRQ_RAISE      = 3'd1,
    IRQ_TRIGGER    = 3'd2,
    IRQ_COND_TRIG  = 3'd3,
    IRQ_CLEAR      = 3'd4,
    IRQ_TRIG_CLEAR = 3'd5
  } irq_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic apply;
  } ctrl_t;

endpackage
`default_nettype wire

// File: hdl/cqm_ctrl.sv
// Command sequencer: capture, ring-distance step, state update.
`timescale 1ns / 1ps
`default_nettype none
module cqm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  output cqm_pkg::ctrl_t      ctrl
);
  import cqm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CALC;
      end
      S_CALC:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    ctrl.capture = 1'b0;
    ctrl.calc    = 1'b0;
    ctrl.apply   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy         = 1'b0;
        ctrl.capture = start;
      end
      S_CALC:  ctrl.calc  = 1'b1;
      S_APPLY: ctrl.apply = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/cqm_datapath.sv
// Ring pointers, config registers, entry packing and result registers.
`timescale 1ns / 1ps
`default_nettype none
module cqm_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cqm_pkg::ctrl_t                     ctrl,
  input  wire logic                               cfg_wr,
  input  wire logic [cqm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cqm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [2:0]                         in_cmd,
  input  wire logic [cqm_pkg::IDX_W-1:0]          in_sq_head,
  input  wire logic [cqm_pkg::IDX_W-1:0]          in_sq_id,
  input  wire logic [cqm_pkg::IDX_W-1:0]          in_cmd_id,
  input  wire logic [cqm_pkg::STATUS_W-1:0]       in_status,
  input  wire logic [cqm_pkg::DW_W-1:0]           in_completion_dword0,
  input  wire logic [cqm_pkg::IDX_W-1:0]          in_doorbell_head,
  input  wire logic                               in_trigger_irqs,
  output logic                                    out_valid,
  output logic                                    out_granted,
  output logic                                    out_entry_valid,
  output logic [cqm_pkg::IDX_W-1:0]               out_entry_slot,
  output logic [cqm_pkg::DW_W-1:0]                out_entry_lower,
  output logic                                    out_lower_valid,
  output logic [cqm_pkg::UPPER_W-1:0]             out_entry_upper,
  output logic [cqm_pkg::IDX_W-1:0]               out_event_index,
  output logic                                    out_event_index_valid,
  output logic [2:0]                              out_irq_action,
  output logic                                    out_head_rejected,
  output logic                                    out_flushed
);
  import cqm_pkg::*;

  // config
  logic [IDX_W-1:0] qsize_r;
  logic             irq_en_r;

  // queue state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             phase_r, phase_nxt;
  logic [IDX_W-1:0] pend_r, pend_nxt;

  // captured command
  logic [2:0]          cmd_r;
  logic [IDX_W-1:0]    sqh_r, sqid_r, cid_r, dbh_r;
  logic [STATUS_W-1:0] st_r;
  logic [DW_W-1:0]     dw0_r;
  logic                trig_r;

  // intermediate step
  logic [IDX_W-1:0] dist_r;
  logic [IDX_W:0]   ev_sum_r;
  logic             rej_r;
  logic [IDX_W-1:0] h_eff;
  logic [IDX_W:0]   dist_full;

  // results
  logic                 valid_r;
  logic                 granted_r, granted_nxt;
  logic                 ent_v_r, ent_v_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [DW_W-1:0]      lower_r, lower_nxt;
  logic                 low_v_r, low_v_nxt;
  logic [UPPER_W-1:0]   upper_r, upper_nxt;
  logic [IDX_W-1:0]     ev_r, ev_nxt;
  logic                 ev_v_r, ev_v_nxt;
  logic [2:0]           irq_r, irq_nxt;
  logic                 rejected_r, rejected_nxt;
  logic                 flushed_r, flushed_nxt;

  logic [IDX_W:0]       tail_inc;
  logic [IDX_W:0]       ev_wrap;
  logic [UPPER_W-1:0]   upper_pack;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qsize_r  <= QSIZE_RESET;
      irq_en_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_QUEUE_SIZE) qsize_r <= cfg_data;
      else if (cfg_index == CFG_IRQ_ENABLED) irq_en_r <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r  <= in_cmd;
      sqh_r  <= in_sq_head;
      sqid_r <= in_sq_id;
      cid_r  <= in_cmd_id;
      st_r   <= in_status;
      dw0_r  <= in_completion_dword0;
      dbh_r  <= in_doorbell_head;
      trig_r <= in_trigger_irqs;
    end
  end

  // A stale head at or beyond the ring size counts as zero.
  assign h_eff = (head_r >= qsize_r) ? '0 : head_r;
  assign dist_full = (dbh_r >= h_eff) ? ({1'b0, dbh_r} - {1'b0, h_eff})
                   : ({1'b0, qsize_r} + {1'b0, dbh_r} - {1'b0, h_eff});

  always_ff @(posedge clk) begin
    if (ctrl.calc) begin
      dist_r   <= dist_full[IDX_W-1:0];
      ev_sum_r <= {1'b0, dbh_r} + {2'b00, qsize_r[IDX_W-1:1]};
      rej_r    <= (dbh_r >= qsize_r);
    end
  end

  assign tail_inc = {1'b0, tail_r} + 17'd1;
  assign ev_wrap  = (ev_sum_r >= {1'b0, qsize_r}) ? (ev_sum_r - {1'b0, qsize_r}) : ev_sum_r;

  always_comb begin
    upper_pack = '0;
    upper_pack[SQID_LSB-1:0]           = sqh_r;
    upper_pack[CMDID_LSB-1:SQID_LSB]   = (cmd_r == CMD_WRITE_IO) ? sqid_r : '0;
    upper_pack[PHASE_POS-1:CMDID_LSB]  = cid_r;
    upper_pack[PHASE_POS]              = phase_r;
    upper_pack[UPPER_W-1:STATUS_LSB]   = st_r;
  end

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    phase_nxt    = phase_r;
    pend_nxt     = pend_r;
    granted_nxt  = 1'b0;
    ent_v_nxt    = 1'b0;
    slot_nxt     = '0;
    lower_nxt    = '0;
    low_v_nxt    = 1'b0;
    upper_nxt    = '0;
    ev_nxt       = '0;
    ev_v_nxt     = 1'b0;
    irq_nxt      = IRQ_NONE;
    rejected_nxt = 1'b0;
    flushed_nxt  = 1'b0;
    unique case (cmd_r)
      CMD_RESERVE: begin
        if (pend_r != (qsize_r - 16'd1)) begin
          pend_nxt    = pend_r + 16'd1;
          granted_nxt = 1'b1;
        end
      end
      CMD_WRITE_IO, CMD_WRITE_ADMIN: begin
        ent_v_nxt = 1'b1;
        slot_nxt  = tail_r;
        upper_nxt = upper_pack;
        if (cmd_r == CMD_WRITE_ADMIN) begin
          lower_nxt = dw0_r;
          low_v_nxt = 1'b1;
        end
        if (tail_inc >= {1'b0, qsize_r}) begin
          tail_nxt  = '0;
          phase_nxt = ~phase_r;
        end else begin
          tail_nxt = tail_inc[IDX_W-1:0];
        end
        if (irq_en_r) irq_nxt = (cmd_r == CMD_WRITE_IO) ? IRQ_RAISE : IRQ_TRIGGER;
      end
      CMD_DOORBELL: begin
        if (rej_r) begin
          rejected_nxt = 1'b1;
        end else begin
          if (dbh_r != head_r) begin
            pend_nxt = (pend_r > dist_r) ? (pend_r - dist_r) : '0;
            head_nxt = dbh_r;
            ev_nxt   = ev_wrap[IDX_W-1:0];
            ev_v_nxt = 1'b1;
          end
          if (irq_en_r && trig_r) irq_nxt = (tail_r != dbh_r) ? IRQ_COND_TRIG : IRQ_CLEAR;
        end
      end
      CMD_FLUSH: begin
        if ((dbh_r != tail_r) && irq_en_r) begin
          irq_nxt     = IRQ_TRIG_CLEAR;
          flushed_nxt = 1'b1;
        end
      end
      default: ;  // unused codes: no change, all fields zero
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      phase_r <= 1'b1;
      pend_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl.apply;
      if (ctrl.apply) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        phase_r <= phase_nxt;
        pend_r  <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      granted_r  <= granted_nxt;
      ent_v_r    <= ent_v_nxt;
      slot_r     <= slot_nxt;
      lower_r    <= lower_nxt;
      low_v_r    <= low_v_nxt;
      upper_r    <= upper_nxt;
      ev_r       <= ev_nxt;
      ev_v_r     <= ev_v_nxt;
      irq_r      <= irq_nxt;
      rejected_r <= rejected_nxt;
      flushed_r  <= flushed_nxt;
    end
  end

  assign out_valid             = valid_r;
  assign out_granted           = granted_r;
  assign out_entry_valid       = ent_v_r;
  assign out_entry_slot        = slot_r;
  assign out_entry_lower       = lower_r;
  assign out_lower_valid       = low_v_r;
  assign out_entry_upper       = upper_r;
  assign out_event_index       = ev_r;
  assign out_event_index_valid = ev_v_r;
  assign out_irq_action        = irq_r;
  assign out_head_rejected     = rejected_r;
  assign out_flushed           = flushed_r;

endmodule
`default_nettype wire

// File: hdl/completion_queue_manager.sv
// Completion ring manager: head/tail/phase/pending bookkeeping per command.
// Each command is captured, then passes the ring-distance step and the state update, and
// its result is registered and strobed; the sequencer takes no new command until that is
// done, and start is taken again during the strobe cycle.
// The receiver cannot stall; each result is shown for one cycle on out_valid.
// Reset (rst_n low, synchronous): head, tail, pending 0, phase 1, queue_size 2, irq off.
`timescale 1ns / 1ps
`default_nettype none
module completion_queue_manager (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cqm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cqm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [2:0]                         in_cmd,
  input  wire logic [cqm_pkg::IDX_W-1:0]          in_sq_head,
  input  wire logic [cqm_pkg::IDX_W-1:0]          in_sq_id,
  input  wire logic [cqm_pkg::IDX_W-1:0]          in_cmd_id,
  input  wire logic [cqm_pkg::STATUS_W-1:0]       in_status,
  input  wire logic [cqm_pkg::DW_W-1:0]           in_completion_dword0,
  input  wire logic [cqm_pkg::IDX_W-1:0]          in_doorbell_head,
  input  wire logic                               in_trigger_irqs,
  output logic                                    out_valid,
  output logic                                    out_granted,
  output logic                                    out_entry_valid,
  output logic [cqm_pkg::IDX_W-1:0]               out_entry_slot,
  output logic [cqm_pkg::DW_W-1:0]                out_entry_lower,
  output logic                                    out_lower_valid,
  output logic [cqm_pkg::UPPER_W-1:0]             out_entry_upper,
  output logic [cqm_pkg::IDX_W-1:0]               out_event_index,
  output logic                                    out_event_index_valid,
  output logic [2:0]                              out_irq_action,
  output logic                                    out_head_rejected,
  output logic                                    out_flushed
);
  import cqm_pkg::*;

  ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  cqm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  cqm_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctrl                  (ctrl),
    .cfg_wr                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_cmd                (in_cmd),
    .in_sq_head            (in_sq_head),
    .in_sq_id              (in_sq_id),
    .in_cmd_id             (in_cmd_id),
    .in_status             (in_status),
    .in_completion_dword0  (in_completion_dword0),
    .in_doorbell_head      (in_doorbell_head),
    .in_trigger_irqs       (in_trigger_irqs),
    .out_valid             (out_valid),
    .out_granted           (out_granted),
    .out_entry_valid       (out_entry_valid),
    .out_entry_slot        (out_entry_slot),
    .out_entry_lower       (out_entry_lower),
    .out_lower_valid       (out_lower_valid),
    .out_entry_upper       (out_entry_upper),
    .out_event_index       (out_event_index),
    .out_event_index_valid (out_event_index_valid),
    .out_irq_action        (out_irq_action),
    .out_head_rejected     (out_head_rejected),
    .out_flushed           (out_flushed)
  );

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted command did not set busy");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_head_rejected) |-> (out_irq_action == IRQ_NONE && !out_event_index_valid))
    else $error("rejected doorbell changed interrupt or event index");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_granted, out_entry_valid, out_event_index_valid,
                            out_head_rejected, out_flushed}))
    else $error("result carries fields of more than one command");
`endif

endmodule
`default_nettype wire
